// ===== hdl/oaie_pkg.sv =====
// package for the ordered array insert/erase unit: field widths, codes and fsm states
`timescale 1ns / 1ps
`default_nettype none

package oaie_pkg;

	localparam int CAPACITY_DEF   = 16;
	localparam int DATA_WIDTH_DEF = 32;

	localparam int ACTION_W = 3;
	localparam int POS_W    = 5;
	localparam int VALUE_W  = 32;
	localparam int COUNT_W  = 5;
	localparam int STATUS_W = 2;

	localparam logic [ACTION_W-1:0] ACT_READ   = 3'd0;
	localparam logic [ACTION_W-1:0] ACT_INSERT = 3'd1;
	localparam logic [ACTION_W-1:0] ACT_ERASE  = 3'd2;
	localparam logic [ACTION_W-1:0] ACT_POP    = 3'd3;
	localparam logic [ACTION_W-1:0] ACT_CLEAR  = 3'd4;
	localparam logic [ACTION_W-1:0] ACT_RESIZE = 3'd5;

	localparam logic [STATUS_W-1:0] STAT_OK     = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_FULL   = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_BADPOS = 2'd2;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ_WAIT,
		S_SHIFT_UP,
		S_SHIFT_DOWN,
		S_DRAIN,
		S_PLACE,
		S_FILL,
		S_FINISH
	} state_t;

endpackage

`default_nettype wire

// ===== hdl/ordered_array_insert_erase_unit.sv =====
// Ordered array with a live count: read, insert, erase, pop, clear and resize.
// The input channel (in_valid/in_ready) carries action, position and item_value;
// the output channel (out_valid/out_ready) returns read_value, element_count and
// status, exactly one result transaction per input transaction, in order.
// Elements sit in a CAPACITY-entry memory with one write and one registered read
// port; insert and erase move one entry per cycle through it.
// Path from acceptance to a result on the output register, by state:
//   pop, clear, failed actions, unused codes, resize that shrinks: straight to finish
//   read: read wait, then finish
//   insert: shift up, drain, place, finish; an append goes straight to place
//   erase: shift down, drain, finish; erasing the last element goes straight to finish
//   resize that grows: fill, one write per new entry, then finish
// One item is in work at a time; the next is taken once
// the result has moved to the output register.
// While a result waits for out_ready the next transaction is still accepted; its
// result is held until the output register frees up.
// Reset clears the live count and all control state; memory contents are not
// reset and an entry is only read after it has been written.
`timescale 1ns / 1ps
`default_nettype none

module ordered_array_insert_erase_unit #(
	parameter int CAPACITY   = oaie_pkg::CAPACITY_DEF,
	parameter int DATA_WIDTH = oaie_pkg::DATA_WIDTH_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic [oaie_pkg::ACTION_W-1:0]       action,
	input  wire logic [oaie_pkg::POS_W-1:0]          position,
	input  wire logic signed [oaie_pkg::VALUE_W-1:0] item_value,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic signed [oaie_pkg::VALUE_W-1:0]      read_value,
	output logic [oaie_pkg::COUNT_W-1:0]             element_count,
	output logic [oaie_pkg::STATUS_W-1:0]            status
);
	import oaie_pkg::*;

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
	localparam logic [CMP_W-1:0] CAP_EXT = CMP_W'(CAPACITY);

	// element memory
	logic [DATA_WIDTH-1:0] mem [CAPACITY];
	logic [DATA_WIDTH-1:0] rdata_q;
	logic                  re;
	logic [IDX_W-1:0]      raddr;
	logic                  we;
	logic [IDX_W-1:0]      waddr;
	logic [DATA_WIDTH-1:0] wdata;

	state_t                state_q, state_d;
	logic [CNT_W-1:0]      count_q, count_d;
	logic [CNT_W-1:0]      newcnt_q, newcnt_d;
	logic [IDX_W-1:0]      addr_q, addr_d;
	logic [IDX_W-1:0]      end_q, end_d;
	logic [DATA_WIDTH-1:0] val_q, val_d;
	logic [DATA_WIDTH-1:0] rd_q, rd_d;
	logic [STATUS_W-1:0]   st_q, st_d;
	logic                  ins_q, ins_d;
	logic                  wpend_s1, wpend_d;
	logic [IDX_W-1:0]      waddr_s1, waddr_d;
	logic                  out_valid_q, out_valid_d;
	logic [VALUE_W-1:0]    rv_q, rv_d;
	logic [COUNT_W-1:0]    ec_q, ec_d;
	logic [STATUS_W-1:0]   status_q, status_d;
	logic [CMP_W-1:0]      pos_ext;
	logic [CMP_W-1:0]      cnt_ext;

	assign pos_ext = CMP_W'(position);
	assign cnt_ext = CMP_W'(count_q);

	// one write port: a pending shift write has priority, fill and place never overlap it
	always_comb begin
		we    = 1'b0;
		waddr = addr_q;
		wdata = val_q;
		if (wpend_s1) begin
			we    = 1'b1;
			waddr = waddr_s1;
			wdata = rdata_q;
		end else if (state_q == S_FILL) begin
			we    = 1'b1;
			waddr = addr_q;
		end else if (state_q == S_PLACE) begin
			we    = 1'b1;
			waddr = end_q;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	always_comb begin
		state_d     = state_q;
		count_d     = count_q;
		newcnt_d    = newcnt_q;
		addr_d      = addr_q;
		end_d       = end_q;
		val_d       = val_q;
		rd_d        = rd_q;
		st_d        = st_q;
		ins_d       = ins_q;
		wpend_d     = 1'b0;
		waddr_d     = waddr_s1;
		out_valid_d = out_valid_q & ~out_ready;
		rv_d        = rv_q;
		ec_d        = ec_q;
		status_d    = status_q;
		in_ready    = 1'b0;
		re          = 1'b0;
		raddr       = addr_q;

		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					val_d   = DATA_WIDTH'($unsigned(item_value));
					rd_d    = '0;
					st_d    = STAT_OK;
					ins_d   = 1'b0;
					state_d = S_FINISH;
					unique case (action)
						ACT_READ: begin
							if (pos_ext < cnt_ext) begin
								re      = 1'b1;
								raddr   = IDX_W'(pos_ext);
								state_d = S_READ_WAIT;
							end else begin
								st_d = STAT_BADPOS;
							end
						end
						ACT_INSERT: begin
							if (cnt_ext >= CAP_EXT) begin
								st_d = STAT_FULL;
							end else if (pos_ext > cnt_ext) begin
								st_d = STAT_BADPOS;
							end else begin
								newcnt_d = CNT_W'(cnt_ext + 1'b1);
								end_d    = IDX_W'(pos_ext);
								ins_d    = 1'b1;
								if (pos_ext == cnt_ext) begin
									state_d = S_PLACE;
								end else begin
									addr_d  = IDX_W'(cnt_ext - 1'b1);
									state_d = S_SHIFT_UP;
								end
							end
						end
						ACT_ERASE: begin
							if (count_q == '0 || pos_ext >= cnt_ext) begin
								st_d = STAT_BADPOS;
							end else if (pos_ext == cnt_ext - 1'b1) begin
								count_d = count_q - 1'b1;
							end else begin
								newcnt_d = count_q - 1'b1;
								addr_d   = IDX_W'(pos_ext + 1'b1);
								end_d    = IDX_W'(cnt_ext - 1'b1);
								state_d  = S_SHIFT_DOWN;
							end
						end
						ACT_POP: begin
							if (count_q == '0) begin
								st_d = STAT_BADPOS;
							end else begin
								count_d = count_q - 1'b1;
							end
						end
						ACT_CLEAR: begin
							count_d = '0;
						end
						ACT_RESIZE: begin
							if (pos_ext > CAP_EXT) begin
								st_d = STAT_FULL;
							end else if (pos_ext > cnt_ext) begin
								newcnt_d = CNT_W'(pos_ext);
								addr_d   = IDX_W'(cnt_ext);
								end_d    = IDX_W'(pos_ext - 1'b1);
								state_d  = S_FILL;
							end else begin
								count_d = CNT_W'(pos_ext);
							end
						end
						default: begin
							// unused codes: no change, status ok
						end
					endcase
				end
			end
			S_READ_WAIT: begin
				rd_d    = rdata_q;
				state_d = S_FINISH;
			end
			S_SHIFT_UP: begin
				// read entry addr, written in the following cycle one place up
				re      = 1'b1;
				wpend_d = 1'b1;
				waddr_d = IDX_W'(addr_q + 1'b1);
				if (addr_q == end_q) begin
					state_d = S_DRAIN;
				end else begin
					addr_d = addr_q - 1'b1;
				end
			end
			S_SHIFT_DOWN: begin
				re      = 1'b1;
				wpend_d = 1'b1;
				waddr_d = addr_q - 1'b1;
				if (addr_q == end_q) begin
					state_d = S_DRAIN;
				end else begin
					addr_d = IDX_W'(addr_q + 1'b1);
				end
			end
			S_DRAIN: begin
				if (ins_q) begin
					state_d = S_PLACE;
				end else begin
					count_d = newcnt_q;
					state_d = S_FINISH;
				end
			end
			S_PLACE: begin
				count_d = newcnt_q;
				state_d = S_FINISH;
			end
			S_FILL: begin
				if (addr_q == end_q) begin
					count_d = newcnt_q;
					state_d = S_FINISH;
				end else begin
					addr_d = IDX_W'(addr_q + 1'b1);
				end
			end
			S_FINISH: begin
				// hold the result until the output register is free
				if (!out_valid_q || out_ready) begin
					out_valid_d = 1'b1;
					rv_d        = VALUE_W'(rd_q);
					ec_d        = COUNT_W'(count_q);
					status_d    = st_q;
					state_d     = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			wpend_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			ins_q       <= 1'b0;
		end else begin
			state_q     <= state_d;
			count_q     <= count_d;
			wpend_s1    <= wpend_d;
			out_valid_q <= out_valid_d;
			ins_q       <= ins_d;
		end
	end

	always_ff @(posedge clk) begin
		newcnt_q <= newcnt_d;
		addr_q   <= addr_d;
		end_q    <= end_d;
		val_q    <= val_d;
		rd_q     <= rd_d;
		st_q     <= st_d;
		waddr_s1 <= waddr_d;
		rv_q     <= rv_d;
		ec_q     <= ec_d;
		status_q <= status_d;
	end

	assign out_valid     = out_valid_q;
	assign read_value    = rv_q;
	assign element_count = ec_q;
	assign status        = status_q;

endmodule

`default_nettype wire

// ===== dv/oaie_checker.sv =====
// result checker for the ordered array unit: array predictor and in-order result compare
`timescale 1ns / 1ps

module oaie_checker #(
	parameter int CAPACITY = oaie_pkg::CAPACITY_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  logic                                in_ready,
	input  logic [oaie_pkg::ACTION_W-1:0]       action,
	input  logic [oaie_pkg::POS_W-1:0]          position,
	input  logic signed [oaie_pkg::VALUE_W-1:0] item_value,
	input  logic                                out_valid,
	input  logic                                out_ready,
	input  logic signed [oaie_pkg::VALUE_W-1:0] read_value,
	input  logic [oaie_pkg::COUNT_W-1:0]        element_count,
	input  logic [oaie_pkg::STATUS_W-1:0]       status,
	output int                                  mismatches,
	output int                                  outstanding
);
	import oaie_pkg::*;

	typedef struct {
		logic [VALUE_W-1:0]  value;
		logic [COUNT_W-1:0]  count;
		logic [STATUS_W-1:0] stat;
	} array_result_t;

	logic [VALUE_W-1:0] slots [CAPACITY];
	int                 fill_level = 0;
	array_result_t      pending_results [$];

	task automatic flag_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		mismatches++;
	endtask

	// apply one transaction to the shadow array and queue the result it should give
	task automatic predict_array_op(input logic [ACTION_W-1:0] act, input logic [POS_W-1:0] pos,
			input logic [VALUE_W-1:0] val);
		array_result_t res;
		int i;
		res.value = '0;
		res.stat  = STAT_OK;
		case (act)
			ACT_READ: begin
				if (pos < fill_level)
					res.value = slots[pos];
				else
					res.stat = STAT_BADPOS;
			end
			ACT_INSERT: begin
				// the full check wins over the position check
				if (fill_level >= CAPACITY)
					res.stat = STAT_FULL;
				else if (pos > fill_level)
					res.stat = STAT_BADPOS;
				else begin
					for (i = fill_level; i > pos; i--)
						slots[i] = slots[i-1];
					slots[pos] = val;
					fill_level++;
				end
			end
			ACT_ERASE: begin
				if (fill_level == 0 || pos >= fill_level)
					res.stat = STAT_BADPOS;
				else begin
					for (i = pos; i + 1 < fill_level; i++)
						slots[i] = slots[i+1];
					fill_level--;
				end
			end
			ACT_POP: begin
				if (fill_level == 0)
					res.stat = STAT_BADPOS;
				else
					fill_level--;
			end
			ACT_CLEAR: begin
				fill_level = 0;
			end
			ACT_RESIZE: begin
				if (pos > CAPACITY)
					res.stat = STAT_FULL;
				else begin
					for (i = fill_level; i < pos; i++)
						slots[i] = val;
					fill_level = pos;
				end
			end
			default: begin
				// unused codes do nothing and report ok
			end
		endcase
		res.count = fill_level[COUNT_W-1:0];
		pending_results = {pending_results, res};
	endtask

	always @(posedge clk) begin
		array_result_t exp_res;
		if (arst_n) begin
			if (in_valid && in_ready)
				predict_array_op(action, position, item_value);
			if (out_valid && out_ready) begin
				if (pending_results.size() == 0) begin
					flag_mismatch($sformatf("result with nothing pending: value %h count %0d status %0d",
						read_value, element_count, status));
				end else begin
					exp_res = pending_results.pop_front();
					if (read_value !== exp_res.value)
						flag_mismatch($sformatf("read_value %h, expected %h",
							read_value, exp_res.value));
					if (element_count !== exp_res.count)
						flag_mismatch($sformatf("element_count %0d, expected %0d",
							element_count, exp_res.count));
					if (status !== exp_res.stat)
						flag_mismatch($sformatf("status %0d, expected %0d",
							status, exp_res.stat));
				end
			end
			outstanding = pending_results.size();
		end
	end

endmodule

// ===== dv/tb_top.sv =====
// testbench top for the ordered array unit: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module tb_top;
	import oaie_pkg::*;

	localparam int CAP = CAPACITY_DEF;

	logic                      clk;
	logic                      arst_n = 1'b0;
	logic                      in_valid = 1'b0;
	logic                      in_ready;
	logic [ACTION_W-1:0]       action = ACT_CLEAR;
	logic [POS_W-1:0]          position = '0;
	logic signed [VALUE_W-1:0] item_value = '0;
	logic                      out_valid;
	logic                      out_ready = 1'b0;
	logic signed [VALUE_W-1:0] read_value;
	logic [COUNT_W-1:0]        element_count;
	logic [STATUS_W-1:0]       status;

	int mismatches;
	int outstanding;
	int level = 0;
	bit calm = 1'b0;

	ordered_array_insert_erase_unit #(
		.CAPACITY(CAP),
		.DATA_WIDTH(DATA_WIDTH_DEF)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.action(action),
		.position(position),
		.item_value(item_value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.read_value(read_value),
		.element_count(element_count),
		.status(status)
	);

	oaie_checker #(
		.CAPACITY(CAP)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.action(action),
		.position(position),
		.item_value(item_value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.read_value(read_value),
		.element_count(element_count),
		.status(status),
		.mismatches(mismatches),
		.outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk)
		out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 6);

	initial begin
		#4ms;
		$display("== FAIL ==");
		$finish;
	end

	function automatic logic [VALUE_W-1:0] pick_value();
		case ($urandom_range(9))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return '0;
			3: return '1;
			default: return $urandom();
		endcase
	endfunction

	// one input transaction; level is a rough count kept only to steer positions
	task automatic send_op(input logic [ACTION_W-1:0] a, input logic [POS_W-1:0] p,
			input logic [VALUE_W-1:0] v);
		if (!calm && $urandom_range(99) < 6) begin
			in_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < 30);
		end
		in_valid   <= 1'b1;
		action     <= a;
		position   <= p;
		item_value <= v;
		do
			@(negedge clk);
		while (!in_ready);
		@(posedge clk);
		case (a)
			ACT_INSERT: if (level < CAP && p <= level) level++;
			ACT_ERASE:  if (p < level) level--;
			ACT_POP:    if (level > 0) level--;
			ACT_CLEAR:  level = 0;
			ACT_RESIZE: if (p <= CAP) level = p;
			default: ;
		endcase
	endtask

	initial begin
		logic [ACTION_W-1:0] a;
		logic [POS_W-1:0]    p;
		int                  r;
		int                  hold;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty array corner cases
		send_op(ACT_READ,   5'd0,  32'h1234_5678);
		send_op(ACT_POP,    5'd0,  32'h0);
		send_op(ACT_ERASE,  5'd0,  32'h0);
		send_op(ACT_INSERT, 5'd1,  32'h0);
		send_op(ACT_INSERT, 5'd0,  32'h7FFF_FFFF);
		send_op(ACT_INSERT, 5'd0,  32'h8000_0000);
		send_op(ACT_INSERT, 5'd2,  32'hFFFF_FFFF);
		send_op(ACT_READ,   5'd1,  32'h0);
		send_op(ACT_READ,   5'd3,  32'h0);
		send_op(ACT_ERASE,  5'd3,  32'h0);
		send_op(ACT_ERASE,  5'd0,  32'h0);
		// grow to capacity, then the full and over capacity cases
		send_op(ACT_RESIZE, 5'd16, 32'h0000_0000);
		send_op(ACT_INSERT, 5'd31, 32'h5555_5555);
		send_op(ACT_READ,   5'd15, 32'h0);
		send_op(ACT_READ,   5'd31, 32'h0);
		send_op(ACT_RESIZE, 5'd17, 32'h0);
		send_op(ACT_RESIZE, 5'd31, 32'hAAAA_AAAA);
		send_op(ACT_RESIZE, 5'd16, 32'h0);
		send_op(ACT_ERASE,  5'd15, 32'h0);
		send_op(ACT_POP,    5'd0,  32'h0);
		send_op(ACT_RESIZE, 5'd3,  32'h0);
		send_op(3'd6,       5'd0,  32'h0);
		send_op(3'd7,       5'd31, 32'hAAAA_AAAA);
		send_op(ACT_CLEAR,  5'd31, 32'hFFFF_FFFF);
		send_op(ACT_RESIZE, 5'd5,  32'h5555_5555);

		for (int n = 0; n < 1450; n++) begin
			calm = (n >= 700 && n < 950);
			r = $urandom_range(99);
			hold = $urandom_range(99);
			if (r < 22) begin
				a = ACT_READ;
				p = (level > 0 && hold < 90) ? POS_W'($urandom_range(level - 1))
					: POS_W'($urandom_range(31));
			end else if (r < 44) begin
				a = ACT_INSERT;
				p = (hold < 90) ? POS_W'($urandom_range(level)) : POS_W'($urandom_range(31));
			end else if (r < 62) begin
				a = ACT_ERASE;
				p = (level > 0 && hold < 90) ? POS_W'($urandom_range(level - 1))
					: POS_W'($urandom_range(31));
			end else if (r < 70) begin
				a = ACT_POP;
				p = POS_W'($urandom_range(31));
			end else if (r < 74) begin
				a = ACT_CLEAR;
				p = POS_W'($urandom_range(31));
			end else if (r < 94) begin
				a = ACT_RESIZE;
				p = (hold < 90) ? POS_W'($urandom_range(CAP))
					: POS_W'($urandom_range(31, CAP + 1));
			end else begin
				a = ACTION_W'($urandom_range(7, 6));
				p = POS_W'($urandom_range(31));
			end
			send_op(a, p, pick_value());
		end
		in_valid <= 1'b0;
		calm = 1'b0;

		while (outstanding != 0)
			@(negedge clk);
		repeat (CAP + 8) @(posedge clk);

		if (mismatches == 0 && outstanding == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
